// File: hw/rtl/lbp_code_histogram_top_macros.svh
// Assertion helpers used by the RTL file of the pattern-code histogram block.
`ifndef LBP_CODE_HISTOGRAM_TOP_MACROS_SVH
`define LBP_CODE_HISTOGRAM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/lch_pkg.sv
package lch_pkg;

	// Line buffer depth and the widest region a row may span.
	localparam int MAX_WIDTH = 128;
	localparam int COL_W     = $clog2(MAX_WIDTH);

	// Histogram geometry.
	localparam int NUM_BINS  = 256;
	localparam int BIN_W     = $clog2(NUM_BINS);

	localparam int PIX_W     = 8;
	localparam int ROW_W     = 12;
	localparam int WID_W     = 8;
	localparam int CFG_W     = 12;

	// Register reset values and bounds.
	localparam logic [WID_W-1:0] WIDTH_RESET  = 8'd96;
	localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd54;
	localparam logic [WID_W-1:0] WIDTH_MIN    = 8'd3;
	localparam logic [WID_W-1:0] WIDTH_MAX    = WID_W'(MAX_WIDTH);
	localparam logic [ROW_W-1:0] HEIGHT_MIN   = 12'd3;

	// Register indexes on the configuration port.
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	// Input item function codes.
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// Result item kinds.
	localparam logic KIND_CODE = 1'b0;
	localparam logic KIND_BIN  = 1'b1;

endpackage

// File: hw/rtl/lbp_code_histogram_top.sv
// A result item passes stage 1, stage 2 and the result register before it appears on m_tvalid.
// Throughput: one input item per cycle when m_tready allows; each stage holds one item and the histogram
// read-modify-write is spread over two stages with forwarding, so equal codes back to back cost nothing.
// Reset: arst_n clears the pipeline, counters, window and histogram valid bits at once; the
// line buffers are not cleared and the block is ready as soon as reset is released.
`include "lbp_code_histogram_top_macros.svh"

module lbp_code_histogram_top
	import lch_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Configuration write port.
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// Input stream.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [7:0] pixel, [15:8] bin_index
	input  logic              s_tuser,   // [0] func
	// Result stream.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [7:0] lbp_code, [15:8] bin_count
	output logic              m_tuser,   // [0] kind
	output logic              m_tlast    // region_done
);

	// ------------------------------------------------------------------
	// Configuration registers and their clamped effective values.
	// ------------------------------------------------------------------
	logic [WID_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [WID_W-1:0] eff_width;
	logic [ROW_W-1:0] eff_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IDX_WIDTH) begin
				width_q <= cfg_data[WID_W-1:0];
			end else begin
				height_q <= cfg_data[ROW_W-1:0];
			end
		end
	end

	always_comb begin
		if (width_q < WIDTH_MIN) begin
			eff_width = WIDTH_MIN;
		end else if (width_q > WIDTH_MAX) begin
			eff_width = WIDTH_MAX;
		end else begin
			eff_width = width_q;
		end
		eff_height = (height_q < HEIGHT_MIN) ? HEIGHT_MIN : height_q;
	end

	// ------------------------------------------------------------------
	// Handshake and stage advance. Each stage moves when the one after it
	// is empty or moving; the result register is the last stage.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, out_valid_q;
	logic out_ready, s2_ready, s1_ready;
	logic move_s1, move_s2;
	logic accept;
	logic result_s2;

	assign out_ready = !out_valid_q || m_tready;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign move_s2   = valid_s2 && out_ready;
	assign move_s1   = valid_s1 && s2_ready;
	assign s_tready  = s1_ready;
	assign accept    = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Raster position counters, advanced when a pixel item is accepted.
	// A register write restarts the region.
	// ------------------------------------------------------------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             col_last, row_last;
	logic             pixel_in;

	assign pixel_in = (s_tuser == FUNC_PIXEL);
	assign col_last = ((WID_W'(col_q) + WID_W'(1)) >= eff_width);
	assign row_last = (((ROW_W+1)'(row_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(eff_height));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && pixel_in) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the accepted item plus the two line buffer words of its
	// column, read with a registered port.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] lb_one_q [MAX_WIDTH];
	logic [PIX_W-1:0] lb_two_q [MAX_WIDTH];

	logic             func_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [BIN_W-1:0] bin_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1, done_s1, first_s1;
	logic [PIX_W-1:0] top_s1, mid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= s_tuser;
			pixel_s1 <= s_tdata[7:0];
			bin_s1   <= s_tdata[15:8];
			col_s1   <= col_q;
			emit_s1  <= pixel_in && (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			done_s1  <= col_last && row_last;
			first_s1 <= (col_q == '0) && (row_q == '0);
			top_s1   <= lb_two_q[col_q];
			mid_s1   <= lb_one_q[col_q];
		end
	end

	// The buffers shift down by one row as a pixel leaves stage 1.
	always_ff @(posedge clk) begin
		if (move_s1 && func_s1 == FUNC_PIXEL) begin
			lb_one_q[col_s1] <= pixel_s1;
			lb_two_q[col_s1] <= mid_s1;
		end
	end

	// ------------------------------------------------------------------
	// 3x3 window. Entries 0..2 hold the column two back (top, middle,
	// bottom), 3..5 the column one back; the newest column comes from the
	// line buffers and the incoming pixel. Centre is entry 4.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] win_q [6];
	logic [PIX_W-1:0] centre;
	logic [BIN_W-1:0] code_s1;

	assign centre = win_q[4];

	always_comb begin
		code_s1    = '0;
		code_s1[7] = win_q[0] > centre;
		code_s1[6] = win_q[3] > centre;
		code_s1[5] = top_s1   > centre;
		code_s1[4] = mid_s1   > centre;
		code_s1[3] = pixel_s1 > centre;
		code_s1[2] = win_q[5] > centre;
		code_s1[1] = win_q[2] > centre;
		code_s1[0] = win_q[1] > centre;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (move_s1 && func_s1 == FUNC_PIXEL) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= pixel_s1;
		end
	end

	// ------------------------------------------------------------------
	// Histogram. The bin is read as an item moves into stage 2 and written
	// back as it leaves. A bin written in the same cycle it is read is
	// forwarded. Valid bits make an unwritten bin read as zero; the first
	// pixel of a region clears them all at once, and that clear wins over
	// a write from an older item in the same cycle.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0]    hist_q [NUM_BINS];
	logic [NUM_BINS-1:0] hist_vld_q;

	logic [BIN_W-1:0] addr_s1;
	logic             hist_we, fwd_hit, clear_bins;

	logic             func_s2, emit_s2, done_s2;
	logic [BIN_W-1:0] code_s2;
	logic [PIX_W-1:0] hist_rd_s2, fwd_val_s2;
	logic             vld_rd_s2, fwd_s2;
	logic [PIX_W-1:0] count_s2;

	assign addr_s1    = (func_s1 == FUNC_READ) ? bin_s1 : code_s1;
	assign hist_we    = move_s2 && emit_s2;
	assign fwd_hit    = hist_we && (addr_s1 == code_s2);
	assign clear_bins = move_s1 && (func_s1 == FUNC_PIXEL) && first_s1;
	assign count_s2   = fwd_s2 ? fwd_val_s2 : (vld_rd_s2 ? hist_rd_s2 : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			func_s2    <= func_s1;
			emit_s2    <= emit_s1;
			done_s2    <= done_s1;
			code_s2    <= code_s1;
			hist_rd_s2 <= hist_q[addr_s1];
			vld_rd_s2  <= hist_vld_q[addr_s1];
			fwd_s2     <= fwd_hit;
			fwd_val_s2 <= count_s2 + PIX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_q[code_s2] <= count_s2 + PIX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
		end else if (clear_bins) begin
			hist_vld_q <= '0;
		end else if (hist_we) begin
			hist_vld_q[code_s2] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result register. Border pixels carry no result and are dropped here.
	// ------------------------------------------------------------------
	logic             kind_q, done_q;
	logic [BIN_W-1:0] code_q;
	logic [PIX_W-1:0] count_q;

	assign result_s2 = (func_s2 == FUNC_READ) || emit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2 && result_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			if (func_s2 == FUNC_READ) begin
				kind_q  <= KIND_BIN;
				code_q  <= '0;
				done_q  <= 1'b0;
				count_q <= count_s2;
			end else begin
				kind_q  <= KIND_CODE;
				code_q  <= code_s2;
				done_q  <= done_s2;
				count_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {count_q, code_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = done_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`LCH_ASSERT_SAME(a_col_in_row, clk, arst_n, 1'b1, (WID_W'(col_q) < eff_width),
		"column counter outside the row")
	`LCH_ASSERT_NEXT(a_cfg_restart, clk, arst_n, cfg_we, (col_q == '0 && row_q == '0),
		"register write did not restart the region")
	`LCH_ASSERT_NEXT(a_first_clears, clk, arst_n, clear_bins, (hist_vld_q == '0),
		"histogram not cleared at the first pixel of a region")
	`LCH_ASSERT_SAME(a_bin_fields, clk, arst_n, (m_tvalid && m_tuser == KIND_BIN),
		(m_tdata[7:0] == '0 && !m_tlast), "bin result carries code fields")

endmodule

// File: tb/testbench.sv
module testbench
	import lch_pkg::*;
();

	// The run is cut short here if the block stops moving.
	localparam int unsigned CYCLE_LIMIT = 600000;

	// After the last expected result has come, a pixel that makes no result may still be in flight.
	// The block's pipeline is three stages deep, so the settle wait leaves some margin before a
	// register write.
	localparam int SETTLE_CYCLES = 8;

	// A 3x3 region whose centre ties with some neighbours and lies between others. The first pixel
	// in raster order sits in the lowest byte.
	localparam logic [9*PIX_W-1:0] MIXED_REGION = {
		8'd255, 8'd101, 8'd100,
		8'd0,   8'd100, 8'd200,
		8'd99,  8'd100, 8'd101
	};

	// One expected result item, with the fields of the result stream.
	typedef struct packed {
		logic              kind;
		logic [PIX_W-1:0]  lbp_code;
		logic              region_done;
		logic [BIN_W-1:0]  bin_count;
	} lch_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_IDX_WIDTH;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;   // [7:0] pixel, [15:8] bin_index
	logic              s_tuser = FUNC_PIXEL;   // [0] func
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;   // [7:0] lbp_code, [15:8] bin_count
	logic              m_tuser;   // [0] kind
	logic              m_tlast;   // region_done

	// Results that the block still owes, oldest first.
	lch_result_t pending_results[$];

	// The testbench's own copy of the block: registers, the two rows above the current one, the
	// six pixels of the window that have already passed, the raster position and the histogram.
	logic [WID_W-1:0]  width_setting = WIDTH_RESET;
	logic [ROW_W-1:0]  height_setting = HEIGHT_RESET;
	logic [PIX_W-1:0]  prev_row [MAX_WIDTH];
	logic [PIX_W-1:0]  prev_row2 [MAX_WIDTH];
	logic [PIX_W-1:0]  nbhd [6];
	logic [COL_W-1:0]  px_col = '0;
	logic [ROW_W-1:0]  px_row = '0;
	logic [BIN_W-1:0]  code_count [NUM_BINS];

	// The most recent code predicted; reads aim at it so that filled bins get checked.
	logic [BIN_W-1:0]  last_code = '0;

	// Shared between the test tasks, the result process and the watchdog.
	bit                no_idle = 1'b0;
	int                hold_request = 0;
	int                fail_count = 0;
	int unsigned       cycle_count = 0;

	lbp_code_histogram_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Length of an idle stretch on either side: mostly none or short, now and then long.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			idle_length = 0;
		else if (r < 90)
			idle_length = $urandom_range(1, 3);
		else if (r < 98)
			idle_length = $urandom_range(4, 12);
		else
			idle_length = $urandom_range(20, 60);
	endfunction

	// Appends one expected result behind those already owed.
	function automatic void queue_expected(input lch_result_t res);
		pending_results.insert(pending_results.size(), res);
	endfunction

	// Result side. Every accepted result item is compared with the oldest expectation. The ready
	// line is then chosen for the next edge: a long hold when a test asks for one, always high
	// in stretches without idling, otherwise random stalls.
	always @(posedge clk) begin : result_side
		lch_result_t want;
		int hold_left;
		int stall_left;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result item with no expectation: tuser %0b tdata %h tlast %0b",
						m_tuser, m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, m_tuser);
						fail_count++;
					end
					if (m_tdata[7:0] !== want.lbp_code) begin
						$error("lbp_code: expected %0d, actual %0d", want.lbp_code, m_tdata[7:0]);
						fail_count++;
					end
					if (m_tlast !== want.region_done) begin
						$error("region_done: expected %0d, actual %0d", want.region_done, m_tlast);
						fail_count++;
					end
					if (m_tdata[15:8] !== want.bin_count) begin
						$error("bin_count: expected %0d, actual %0d", want.bin_count, m_tdata[15:8]);
						fail_count++;
					end
				end
			end
			// The hold is counted here, in cycles, so the sender can keep offering items meanwhile.
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (no_idle) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = idle_length();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one item after a random gap, waits until the block takes it and then works out what
	// the block must return for it. The valid line stays high after acceptance, so an item that
	// follows with no gap goes out on the very next edge.
	task automatic send_item(input logic fn, input logic [PIX_W-1:0] pix,
		input logic [BIN_W-1:0] bidx);
		int gap;
		int eff_w;
		int eff_h;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] centre;
		logic [BIN_W-1:0] code;
		logic end_of_region;
		lch_result_t res;
		gap = no_idle ? 0 : idle_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {bidx, pix};
		@(posedge clk);
		while (!s_tready) @(posedge clk);

		res = '0;
		if (fn == FUNC_READ) begin
			// A read returns the bin as it stands, including every code counted before it.
			res.kind = KIND_BIN;
			res.bin_count = code_count[bidx];
			queue_expected(res);
		end else begin
			// Widths outside the buffer range are pulled to the nearest legal value, and so are
			// heights below three.
			if (width_setting < WIDTH_MIN)
				eff_w = int'(WIDTH_MIN);
			else if (width_setting > WIDTH_MAX)
				eff_w = int'(WIDTH_MAX);
			else
				eff_w = int'(width_setting);
			eff_h = int'((height_setting < HEIGHT_MIN) ? HEIGHT_MIN : height_setting);

			// The first pixel of a region starts a fresh histogram.
			if (px_col == 0 && px_row == 0)
				foreach (code_count[k])
					code_count[k] = '0;

			top = prev_row2[px_col];
			mid = prev_row[px_col];
			end_of_region = (int'(px_col) + 1 >= eff_w) && (int'(px_row) + 1 >= eff_h);

			// The new pixel is the bottom-right corner of a window centred one row up and one
			// column left. Border pixels complete no window and produce nothing.
			if (px_row >= 2 && px_col >= 2) begin
				centre = nbhd[4];
				code = {nbhd[0] > centre, nbhd[3] > centre, top > centre, mid > centre,
					pix > centre, nbhd[5] > centre, nbhd[2] > centre, nbhd[1] > centre};
				code_count[code] = code_count[code] + 8'd1;
				last_code = code;
				res.kind = KIND_CODE;
				res.lbp_code = code;
				res.region_done = end_of_region;
				queue_expected(res);
			end

			prev_row2[px_col] = mid;
			prev_row[px_col] = pix;
			nbhd[0] = nbhd[3];
			nbhd[1] = nbhd[4];
			nbhd[2] = nbhd[5];
			nbhd[3] = top;
			nbhd[4] = mid;
			nbhd[5] = pix;

			if (int'(px_col) + 1 >= eff_w) begin
				px_col = '0;
				if (int'(px_row) + 1 >= eff_h)
					px_row = '0;
				else
					px_row = px_row + ROW_W'(1);
			end else begin
				px_col = px_col + COL_W'(1);
			end
		end
	endtask

	// Stops offering items and waits until every expected result has been taken.
	task automatic await_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Brings the block to rest so that a register may be written.
	task automatic drain_block();
		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register; the block then starts a new region with the next pixel.
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDX_WIDTH)
			width_setting = value[WID_W-1:0];
		else
			height_setting = value[ROW_W-1:0];
		px_col = '0;
		px_row = '0;
	endtask

	// Right after reset every bin reads zero; the lowest and highest bins are asked for.
	task automatic test_reset_bins();
		send_item(FUNC_READ, 8'hFF, 8'd0);
		send_item(FUNC_READ, 8'h00, 8'hFF);
	endtask

	// With the registers at their reset values the third row starts past two full rows of 96
	// pixels, so the first codes only appear near the end of this stretch.
	task automatic test_default_geometry();
		int i;
		for (i = 0; i < 200; i++)
			send_item(FUNC_PIXEL, ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
				8'($urandom));
		send_item(FUNC_READ, 8'($urandom), last_code);
	endtask

	// Two smallest regions, each yielding exactly one code on its last pixel. The first has a
	// black centre in a white ring, so every bit is set. The second has ties and values on both
	// sides of the centre, which exposes a greater-or-equal compare or a misplaced bit. The
	// second region must also have cleared the histogram left by the first.
	task automatic test_window_codes();
		int k;
		drain_block();
		write_reg(CFG_IDX_WIDTH, 12'd3);
		write_reg(CFG_IDX_HEIGHT, 12'd3);
		for (k = 0; k < 9; k++)
			send_item(FUNC_PIXEL, (k == 4) ? 8'd0 : 8'd255, 8'($urandom));
		send_item(FUNC_READ, 8'($urandom), 8'hFF);
		for (k = 0; k < 9; k++)
			send_item(FUNC_PIXEL, MIXED_REGION[k*PIX_W +: PIX_W], 8'($urandom));
		send_item(FUNC_READ, 8'($urandom), last_code);
		send_item(FUNC_READ, 8'($urandom), 8'hFF);
	endtask

	// A width above the buffer depth, with junk in the upper data bits, must act as the widest
	// row. A flat image puts all 378 codes of this region into bin zero, so the bin wraps past
	// 255. The few pixels after the region start a new one, which clears the histogram again.
	task automatic test_widest_flat_region();
		int i;
		logic [PIX_W-1:0] level;
		drain_block();
		write_reg(CFG_IDX_WIDTH, {4'hA, 8'd255});
		write_reg(CFG_IDX_HEIGHT, 12'd5);
		level = 8'($urandom);
		for (i = 0; i < 640; i++) begin
			send_item(FUNC_PIXEL, level, 8'($urandom));
			if ($urandom_range(0, 19) == 0)
				send_item(FUNC_READ, 8'($urandom),
					($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom));
		end
		send_item(FUNC_READ, 8'($urandom), 8'd0);
		for (i = 0; i < 5; i++)
			send_item(FUNC_PIXEL, level, 8'($urandom));
		send_item(FUNC_READ, 8'($urandom), 8'd0);
	endtask

	// The receiver holds off for a long time while items keep coming back to back, so the
	// pipeline fills and the input stalls. Afterwards the sender pauses until every result is
	// back and then carries on inside the same region.
	task automatic test_output_hold();
		int i;
		drain_block();
		write_reg(CFG_IDX_WIDTH, 12'd4);
		write_reg(CFG_IDX_HEIGHT, 12'd3);
		no_idle = 1'b1;
		hold_request = 150;
		for (i = 0; i < 40; i++)
			send_item((i % 7 == 6) ? FUNC_READ : FUNC_PIXEL, 8'($urandom), 8'($urandom));
		await_results();
		for (i = 0; i < 20; i++)
			send_item(FUNC_PIXEL, 8'($urandom), 8'($urandom));
		no_idle = 1'b0;
	endtask

	// Random phases, each under a fresh geometry. The first ones force widths and heights below
	// the legal range and the tallest height; later ones are mostly small regions, so that many
	// rows end and many regions complete. Pixels often cluster around one level so that ties
	// with the centre are common. Phases end at random points, so a write often restarts a region
	// half way through.
	task automatic test_random_regions();
		int phase;
		int n;
		int i;
		int r;
		logic [WID_W-1:0] w;
		logic [ROW_W-1:0] h;
		logic [PIX_W-1:0] base;
		logic [PIX_W-1:0] pix;
		for (phase = 0; phase < 9; phase++) begin
			drain_block();
			case (phase)
				0: begin
					w = 8'd1;
					h = 12'd0;
				end
				1: begin
					w = 8'd0;
					h = 12'd2;
				end
				2: begin
					w = 8'd3;
					h = 12'd4095;
				end
				default: begin
					r = $urandom_range(0, 99);
					if (r < 70)
						w = WID_W'($urandom_range(3, 8));
					else if (r < 85)
						w = WID_W'($urandom_range(0, 2));
					else
						w = WID_W'($urandom_range(9, 24));
					r = $urandom_range(0, 99);
					if (r < 60)
						h = ROW_W'($urandom_range(0, 6));
					else if (r < 85)
						h = ROW_W'($urandom_range(7, 30));
					else
						h = ROW_W'($urandom_range(31, 4095));
				end
			endcase
			if ($urandom_range(0, 1) != 0) begin
				write_reg(CFG_IDX_WIDTH, {4'($urandom), w});
				write_reg(CFG_IDX_HEIGHT, h);
			end else begin
				write_reg(CFG_IDX_HEIGHT, h);
				write_reg(CFG_IDX_WIDTH, {4'($urandom), w});
			end
			no_idle = ($urandom_range(0, 3) == 0);
			base = 8'($urandom);
			n = $urandom_range(10, 18);
			for (i = 0; i < n; i++) begin
				if (i == n / 2 && $urandom_range(0, 2) == 0)
					await_results();
				if ($urandom_range(0, 99) < 15) begin
					send_item(FUNC_READ, 8'($urandom),
						($urandom_range(0, 4) < 3) ? last_code : 8'($urandom));
				end else begin
					r = $urandom_range(0, 99);
					if (r < 40)
						pix = 8'($urandom);
					else if (r < 80)
						pix = base + 8'($urandom_range(0, 3));
					else if (r < 90)
						pix = 8'd0;
					else
						pix = 8'd255;
					send_item(FUNC_PIXEL, pix, 8'($urandom));
				end
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		foreach (prev_row[k]) begin
			prev_row[k] = '0;
			prev_row2[k] = '0;
		end
		foreach (nbhd[k])
			nbhd[k] = '0;
		foreach (code_count[k])
			code_count[k] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_bins();
		test_default_geometry();
		test_window_codes();
		test_widest_flat_region();
		test_output_hold();
		test_random_regions();

		drain_block();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
